[rtl/aid_pkg.sv]
package aid_pkg;

   // field widths
   localparam int WORD_W = 32;
   localparam int ADDR_W = 64;
   localparam int MN_W   = 6;
   localparam int REG_W  = 5;

   // mnemonic codes
   localparam logic [MN_W-1:0] MN_UNKNOWN   = 6'd0;
   localparam logic [MN_W-1:0] MN_B         = 6'd1;
   localparam logic [MN_W-1:0] MN_BL        = 6'd2;
   localparam logic [MN_W-1:0] MN_BX        = 6'd3;
   localparam logic [MN_W-1:0] MN_BLX       = 6'd4;
   localparam logic [MN_W-1:0] MN_LDR       = 6'd5;
   localparam logic [MN_W-1:0] MN_LDRB      = 6'd6;
   localparam logic [MN_W-1:0] MN_STR       = 6'd7;
   localparam logic [MN_W-1:0] MN_STRB      = 6'd8;
   localparam logic [MN_W-1:0] MN_LDRSH     = 6'd9;
   localparam logic [MN_W-1:0] MN_LDRSB     = 6'd10;
   localparam logic [MN_W-1:0] MN_LDRH      = 6'd11;
   localparam logic [MN_W-1:0] MN_STRH      = 6'd12;
   localparam logic [MN_W-1:0] MN_LDM       = 6'd13;
   localparam logic [MN_W-1:0] MN_STM       = 6'd14;
   localparam logic [MN_W-1:0] MN_VMOV_RRD  = 6'd15;
   localparam logic [MN_W-1:0] MN_VMOV_DRR  = 6'd16;
   localparam logic [MN_W-1:0] MN_VMOV_F    = 6'd17;
   localparam logic [MN_W-1:0] MN_VMOV_RS   = 6'd18;
   localparam logic [MN_W-1:0] MN_VMOV_SR   = 6'd19;
   localparam logic [MN_W-1:0] MN_SCVTF     = 6'd20;
   localparam logic [MN_W-1:0] MN_UCVTF     = 6'd21;
   localparam logic [MN_W-1:0] MN_FCVTNS    = 6'd22;
   localparam logic [MN_W-1:0] MN_VLDR      = 6'd23;
   localparam logic [MN_W-1:0] MN_VSTR      = 6'd24;
   localparam logic [MN_W-1:0] MN_SVC       = 6'd25;
   localparam logic [MN_W-1:0] MN_MUL       = 6'd26;
   localparam logic [MN_W-1:0] MN_MOVW      = 6'd27;
   localparam logic [MN_W-1:0] MN_MOVT      = 6'd28;
   localparam logic [MN_W-1:0] MN_ALU_BASE  = 6'd29;
   localparam logic [MN_W-1:0] MN_VADD      = 6'd45;
   localparam logic [MN_W-1:0] MN_VSUB      = 6'd46;
   localparam logic [MN_W-1:0] MN_VMUL      = 6'd47;
   localparam logic [MN_W-1:0] MN_VDIV      = 6'd48;

   // alu opcodes that need special handling
   localparam logic [3:0] OPC_TST = 4'd8;
   localparam logic [3:0] OPC_CMN = 4'd11;
   localparam logic [3:0] OPC_MOV = 4'd13;
   localparam logic [3:0] OPC_MVN = 4'd15;

   // decode masks and match patterns
   localparam logic [31:0] BR_MASK      = 32'h0e000000;
   localparam logic [31:0] BR_MATCH     = 32'h0a000000;
   localparam logic [31:0] BX_MASK      = 32'h0ffffff0;
   localparam logic [31:0] BX_MATCH     = 32'h012fff10;
   localparam logic [31:0] BLX_MATCH    = 32'h012fff30;
   localparam logic [31:0] HW_MASK      = 32'h0e000090;
   localparam logic [31:0] HW_MATCH     = 32'h00000090;
   localparam logic [31:0] VM_MASK      = 32'h0ff00f10;
   localparam logic [31:0] VPAIR_A      = 32'h0c400b10;
   localparam logic [31:0] VPAIR_B      = 32'h0c500b10;
   localparam logic [31:0] VMOVF_MASK   = 32'h0fbf0fd0;
   localparam logic [31:0] VMOVF_S      = 32'h0eb00a40;
   localparam logic [31:0] VMOVF_D      = 32'h0eb00b40;
   localparam logic [31:0] VSGL_MASK    = 32'h0fb00f10;
   localparam logic [31:0] VSGL_TO      = 32'h0e000a10;
   localparam logic [31:0] VSGL_FROM    = 32'h0e100a10;
   localparam logic [31:0] CVT_S        = 32'h0e000b10;
   localparam logic [31:0] CVT_U        = 32'h0e400b10;
   localparam logic [31:0] CVT_NS       = 32'h0e100b10;
   localparam logic [31:0] MUL_MASK     = 32'h0fe000f0;
   localparam logic [31:0] MUL_MATCH    = 32'h00000090;
   localparam logic [31:0] MOV16_MASK   = 32'h0ff00000;
   localparam logic [31:0] MOVW_MATCH   = 32'h03000000;
   localparam logic [31:0] MOVT_MATCH   = 32'h03400000;
   localparam logic [31:0] VAR_MASK     = 32'h0fb00e50;
   localparam logic [31:0] VADD_MATCH   = 32'h0e300a00;
   localparam logic [31:0] VSUB_MATCH   = 32'h0e300a40;
   localparam logic [31:0] VMUL_MATCH   = 32'h0e200a00;
   localparam logic [31:0] VDIV_MATCH   = 32'h0e800a00;

   typedef struct packed {
      logic [WORD_W-1:0] instruction_word;
      logic [ADDR_W-1:0] instruction_address;
   } req_type;

   typedef struct packed {
      logic [MN_W-1:0]   mnemonic;
      logic [3:0]        condition;
      logic [REG_W-1:0]  reg_a;
      logic [REG_W-1:0]  reg_b;
      logic [REG_W-1:0]  reg_c;
      logic [ADDR_W-1:0] operand_value;
      logic              offset_down;
      logic              writeback;
      logic              pre_index;
      logic              flag_update;
      logic              double_precision;
      logic              operand_is_immediate;
   } rsp_type;

   // vfp register number: single is {field, x}, double is {x, field}
   function automatic logic [REG_W-1:0] vfp_reg(input logic [3:0] f, input logic x,
                                                input logic dbl);
      return dbl ? {x, f} : {f, x};
   endfunction

endpackage

[rtl/aid_if.sv]
interface aid_req_if;
   import aid_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface aid_rsp_if;
   import aid_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[rtl/aid_decode.sv]
module aid_decode (
   input  aid_pkg::req_type req,
   output aid_pkg::rsp_type rsp
);
   import aid_pkg::*;

   logic [31:0]     w;
   logic [31:0]     m;
   logic            load, up, pre, wbit;
   logic [MN_W-1:0] hw_mn;
   logic [63:0]     br_target;
   logic [63:0]     rot_pair;
   logic [31:0]     rot_imm;
   logic [3:0]      opc;
   logic            is_cmp;
   logic [MN_W-1:0] var_mn;

   assign w    = req.instruction_word;
   assign m    = w & VM_MASK;
   assign load = w[20];
   assign up   = w[23];
   assign pre  = w[24];
   assign wbit = w[21];

   // branch target: address + 8 + sign-extended word offset
   assign br_target = req.instruction_address + 64'd8 + {{38{w[23]}}, w[23:0], 2'b00};

   // rotated alu immediate
   assign rot_pair = {w[7:0] == 8'd0 ? 32'd0 : {24'd0, w[7:0]}, 24'd0, w[7:0]}
                     >> {w[11:8], 1'b0};
   assign rot_imm  = rot_pair[31:0];

   assign opc    = w[24:21];
   assign is_cmp = (opc >= OPC_TST) && (opc <= OPC_CMN);

   // halfword and signed transfer selection
   always_comb begin
      hw_mn = MN_UNKNOWN;
      if (load && w[6])
         hw_mn = w[5] ? MN_LDRSH : MN_LDRSB;
      else if (load && w[5])
         hw_mn = MN_LDRH;
      else if (!load && !w[6] && w[5])
         hw_mn = MN_STRH;
   end

   // vfp arithmetic selection
   always_comb begin
      case (w & VAR_MASK)
         VADD_MATCH: var_mn = MN_VADD;
         VSUB_MATCH: var_mn = MN_VSUB;
         VMUL_MATCH: var_mn = MN_VMUL;
         VDIV_MATCH: var_mn = MN_VDIV;
         default:    var_mn = MN_UNKNOWN;
      endcase
   end

   // priority decode, first matching pattern wins
   always_comb begin
      rsp           = '0;
      rsp.condition = w[31:28];
      if ((w & BR_MASK) == BR_MATCH) begin
         rsp.mnemonic      = pre ? MN_BL : MN_B;
         rsp.operand_value = br_target;
      end else if ((w & BX_MASK) == BX_MATCH || (w & BX_MASK) == BLX_MATCH) begin
         rsp.mnemonic = w[5] ? MN_BLX : MN_BX;
         rsp.reg_a    = {1'b0, w[3:0]};
      end else if (w[27:26] == 2'b01) begin
         rsp.mnemonic      = load ? (w[22] ? MN_LDRB : MN_LDR) : (w[22] ? MN_STRB : MN_STR);
         rsp.reg_a         = {1'b0, w[15:12]};
         rsp.reg_b         = {1'b0, w[19:16]};
         rsp.operand_value = {52'd0, w[11:0]};
         rsp.offset_down   = !up;
         rsp.pre_index     = pre;
         rsp.writeback     = pre ? wbit : 1'b1;
      end else if ((w & HW_MASK) == HW_MATCH && hw_mn != MN_UNKNOWN) begin
         rsp.mnemonic      = hw_mn;
         rsp.reg_a         = {1'b0, w[15:12]};
         rsp.reg_b         = {1'b0, w[19:16]};
         rsp.operand_value = {56'd0, w[11:8], w[3:0]};
         rsp.pre_index     = 1'b1;
      end else if (w[27:25] == 3'b100) begin
         rsp.mnemonic      = load ? MN_LDM : MN_STM;
         rsp.reg_b         = {1'b0, w[19:16]};
         rsp.operand_value = {48'd0, w[15:0]};
         rsp.offset_down   = !up;
         rsp.pre_index     = pre;
         rsp.writeback     = wbit;
      end else if (m == VPAIR_A || m == VPAIR_B) begin
         rsp.mnemonic         = load ? MN_VMOV_RRD : MN_VMOV_DRR;
         rsp.reg_a            = {1'b0, w[15:12]};
         rsp.reg_b            = {1'b0, w[19:16]};
         rsp.reg_c            = vfp_reg(w[3:0], w[5], 1'b1);
         rsp.double_precision = 1'b1;
      end else if ((w & VMOVF_MASK) == VMOVF_S || (w & VMOVF_MASK) == VMOVF_D) begin
         rsp.mnemonic         = MN_VMOV_F;
         rsp.reg_a            = vfp_reg(w[15:12], w[22], w[8]);
         rsp.reg_b            = vfp_reg(w[3:0], w[5], w[8]);
         rsp.double_precision = w[8];
      end else if ((w & VSGL_MASK) == VSGL_TO || (w & VSGL_MASK) == VSGL_FROM) begin
         rsp.mnemonic = load ? MN_VMOV_RS : MN_VMOV_SR;
         rsp.reg_a    = {1'b0, w[15:12]};
         rsp.reg_b    = vfp_reg(w[19:16], w[7], 1'b0);
      end else if (m == CVT_S || m == CVT_U) begin
         rsp.mnemonic         = w[22] ? MN_UCVTF : MN_SCVTF;
         rsp.reg_a            = vfp_reg(w[15:12], w[22], w[7]);
         rsp.reg_b            = {1'b0, w[19:16]};
         rsp.double_precision = w[7];
      end else if (m == CVT_NS) begin
         rsp.mnemonic         = MN_FCVTNS;
         rsp.reg_a            = {1'b0, w[15:12]};
         rsp.reg_b            = vfp_reg(w[3:0], w[5], w[7]);
         rsp.double_precision = w[7];
      end else if (w[27:24] == 4'b1101 && w[11:8] >= 4'ha) begin
         rsp.mnemonic         = load ? MN_VLDR : MN_VSTR;
         rsp.reg_a            = vfp_reg(w[15:12], w[22], w[8]);
         rsp.reg_b            = {1'b0, w[19:16]};
         rsp.operand_value    = {54'd0, w[7:0], 2'b00};
         rsp.offset_down      = !up;
         rsp.pre_index        = 1'b1;
         rsp.double_precision = w[8];
      end else if (w[27:24] == 4'b1111) begin
         rsp.mnemonic      = MN_SVC;
         rsp.operand_value = {40'd0, w[23:0]};
      end else if ((w & MUL_MASK) == MUL_MATCH) begin
         rsp.mnemonic      = MN_MUL;
         rsp.reg_a         = {1'b0, w[19:16]};
         rsp.reg_b         = {1'b0, w[3:0]};
         rsp.reg_c         = {1'b0, w[11:8]};
         rsp.operand_value = {60'd0, w[15:12]};
      end else if ((w & MOV16_MASK) == MOVW_MATCH || (w & MOV16_MASK) == MOVT_MATCH) begin
         rsp.mnemonic      = w[22] ? MN_MOVT : MN_MOVW;
         rsp.reg_a         = {1'b0, w[15:12]};
         rsp.operand_value = {48'd0, w[19:16], w[11:0]};
      end else if (w[27:26] == 2'b00) begin
         rsp.mnemonic             = MN_ALU_BASE + {2'b00, opc};
         rsp.reg_a                = is_cmp ? '0 : {1'b0, w[15:12]};
         rsp.reg_b                = (opc == OPC_MOV || opc == OPC_MVN) ? '0
                                                                     : {1'b0, w[19:16]};
         rsp.reg_c                = w[25] ? '0 : {1'b0, w[3:0]};
         rsp.operand_value        = w[25] ? {32'd0, rot_imm} : '0;
         rsp.flag_update          = load && !is_cmp;
         rsp.operand_is_immediate = w[25];
      end else if (var_mn != MN_UNKNOWN) begin
         rsp.mnemonic         = var_mn;
         rsp.reg_a            = vfp_reg(w[15:12], w[22], w[8]);
         rsp.reg_b            = vfp_reg(w[19:16], w[7], w[8]);
         rsp.reg_c            = vfp_reg(w[3:0], w[5], w[8]);
         rsp.double_precision = w[8];
      end
   end

endmodule

[rtl/arm_instruction_decoder_top.sv]
// A32 decoder: input register, one level of decode logic, result register.
// Each request is held in the input register, decoded, and its result is
// held in the result register, from which rsp is driven.
// Throughput: one instruction per cycle while rsp is ready; the decode logic and the 64-bit
// branch-target adder sit between the two registers.
// Reset (synchronous, active high) clears both valid flags; payloads are not reset.
module arm_instruction_decoder_top (
   input logic      clock,
   input logic      reset,
   aid_req_if.sink  req_if,
   aid_rsp_if.source rsp_if
);
   import aid_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type dec_rsp;
   logic    out_load;
   logic    in_load;

   // decode of the held request
   aid_decode u_decode (
      .req (in_data_ff),
      .rsp (dec_rsp)
   );

   // pipeline advance
   assign out_load     = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign in_load      = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || out_load;
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_if.ready);

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_if.data;
      end
      if (out_load) begin
         out_data_ff <= dec_rsp;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

endmodule

[bench/tb_arm_instruction_decoder_top.sv]
`timescale 1ns / 100ps

module tb_arm_instruction_decoder_top;
   import aid_pkg::*;

   // encodings the package leaves implicit
   localparam logic [31:0] SDT_MASK    = 32'h0c000000;
   localparam logic [31:0] SDT_MATCH   = 32'h04000000;
   localparam logic [31:0] BDT_MASK    = 32'h0e000000;
   localparam logic [31:0] BDT_MATCH   = 32'h08000000;
   localparam logic [31:0] COP_MASK    = 32'h0f000000;
   localparam logic [31:0] VLS_MATCH   = 32'h0d000000;
   localparam logic [31:0] SVC_MATCH   = 32'h0f000000;
   localparam logic [31:0] ALU_MASK    = 32'h0c000000;
   localparam logic [31:0] ALU_MATCH   = 32'h00000000;
   localparam logic [3:0]  VFP_CP_MIN  = 4'ha;

   localparam int NUM_FORMS     = 25;
   localparam int PHASE_ITEMS   = 560;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct {
      logic [31:0] word;
      logic [63:0] addr;
      bit          typed;
      rsp_type     want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   bit      row_typed;
   rsp_type row_typed_rsp;
   int      send_idle_pct;
   int      rcv_idle_pct;
   bit      holdoff_due;
   bit      holdoff_done;
   int      errors;
   int      rsp_count;
   int      cycle_count;
   int      random_sent;

   rsp_type     expected_decodes[$];
   dir_row_type dir_rows[$];

   aid_req_if req_ch ();
   aid_rsp_if rsp_ch ();

   arm_instruction_decoder_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // vfp register number from a 4-bit field and its extra bit
   function automatic logic [4:0] vreg(input logic [31:0] w, input int pos4, input int xpos,
                                       input logic dbl);
      logic [4:0] n;
      if (dbl) n = {w[xpos], w[pos4 +: 4]};
      else n = {w[pos4 +: 4], w[xpos]};
      return n;
   endfunction

   // what the decoder should give for one word at one address
   function automatic rsp_type decode_a32(input logic [31:0] w, input logic [63:0] addr);
      rsp_type     r;
      logic        ld;
      logic        up;
      logic        pre;
      logic        wbit;
      logic        dp;
      logic        is_cmp;
      logic [3:0]  opc;
      logic [31:0] vm_bits;
      logic [63:0] twice;
      logic [MN_W-1:0] hw_mn;
      r = '0;
      r.condition = w[31:28];
      ld = w[20];
      up = w[23];
      pre = w[24];
      wbit = w[21];
      vm_bits = w & VM_MASK;

      // halfword and signed forms, some combinations fall through
      hw_mn = MN_UNKNOWN;
      if ((w & HW_MASK) == HW_MATCH) begin
         if (ld && w[6]) hw_mn = w[5] ? MN_LDRSH : MN_LDRSB;
         else if (ld && w[5]) hw_mn = MN_LDRH;
         else if (!ld && !w[6] && w[5]) hw_mn = MN_STRH;
      end

      if ((w & BR_MASK) == BR_MATCH) begin
         r.mnemonic = pre ? MN_BL : MN_B;
         r.operand_value = addr + 64'd8 + {{38{w[23]}}, w[23:0], 2'b00};
      end else if ((w & BX_MASK) == BX_MATCH || (w & BX_MASK) == BLX_MATCH) begin
         r.mnemonic = w[5] ? MN_BLX : MN_BX;
         r.reg_a = {1'b0, w[3:0]};
      end else if ((w & SDT_MASK) == SDT_MATCH) begin
         r.mnemonic = ld ? (w[22] ? MN_LDRB : MN_LDR) : (w[22] ? MN_STRB : MN_STR);
         r.reg_a = {1'b0, w[15:12]};
         r.reg_b = {1'b0, w[19:16]};
         r.operand_value = {52'd0, w[11:0]};
         r.offset_down = ~up;
         r.pre_index = pre;
         r.writeback = pre ? wbit : 1'b1;
      end else if (hw_mn != MN_UNKNOWN) begin
         r.mnemonic = hw_mn;
         r.reg_a = {1'b0, w[15:12]};
         r.reg_b = {1'b0, w[19:16]};
         r.operand_value = {56'd0, w[11:8], w[3:0]};
         r.pre_index = 1'b1;
      end else if ((w & BDT_MASK) == BDT_MATCH) begin
         r.mnemonic = ld ? MN_LDM : MN_STM;
         r.reg_b = {1'b0, w[19:16]};
         r.operand_value = {48'd0, w[15:0]};
         r.offset_down = ~up;
         r.pre_index = pre;
         r.writeback = wbit;
      end else if (vm_bits == VPAIR_A || vm_bits == VPAIR_B) begin
         r.mnemonic = ld ? MN_VMOV_RRD : MN_VMOV_DRR;
         r.reg_a = {1'b0, w[15:12]};
         r.reg_b = {1'b0, w[19:16]};
         r.reg_c = vreg(w, 0, 5, 1'b1);
         r.double_precision = 1'b1;
      end else if ((w & VMOVF_MASK) == VMOVF_S || (w & VMOVF_MASK) == VMOVF_D) begin
         dp = w[8];
         r.mnemonic = MN_VMOV_F;
         r.reg_a = vreg(w, 12, 22, dp);
         r.reg_b = vreg(w, 0, 5, dp);
         r.double_precision = dp;
      end else if ((w & VSGL_MASK) == VSGL_TO || (w & VSGL_MASK) == VSGL_FROM) begin
         r.mnemonic = ld ? MN_VMOV_RS : MN_VMOV_SR;
         r.reg_a = {1'b0, w[15:12]};
         r.reg_b = vreg(w, 16, 7, 1'b0);
      end else if (vm_bits == CVT_S || vm_bits == CVT_U) begin
         // bit 22 is both the unsigned flag and the single register's extra bit
         dp = w[7];
         r.mnemonic = w[22] ? MN_UCVTF : MN_SCVTF;
         r.reg_a = vreg(w, 12, 22, dp);
         r.reg_b = {1'b0, w[19:16]};
         r.double_precision = dp;
      end else if (vm_bits == CVT_NS) begin
         dp = w[7];
         r.mnemonic = MN_FCVTNS;
         r.reg_a = {1'b0, w[15:12]};
         r.reg_b = vreg(w, 0, 5, dp);
         r.double_precision = dp;
      end else if ((w & COP_MASK) == VLS_MATCH && w[11:8] >= VFP_CP_MIN) begin
         dp = w[8];
         r.mnemonic = ld ? MN_VLDR : MN_VSTR;
         r.reg_a = vreg(w, 12, 22, dp);
         r.reg_b = {1'b0, w[19:16]};
         r.operand_value = {54'd0, w[7:0], 2'b00};
         r.offset_down = ~up;
         r.pre_index = 1'b1;
         r.double_precision = dp;
      end else if ((w & COP_MASK) == SVC_MATCH) begin
         r.mnemonic = MN_SVC;
         r.operand_value = {40'd0, w[23:0]};
      end else if ((w & MUL_MASK) == MUL_MATCH) begin
         r.mnemonic = MN_MUL;
         r.reg_a = {1'b0, w[19:16]};
         r.reg_b = {1'b0, w[3:0]};
         r.reg_c = {1'b0, w[11:8]};
         r.operand_value = {60'd0, w[15:12]};
      end else if ((w & MOV16_MASK) == MOVW_MATCH || (w & MOV16_MASK) == MOVT_MATCH) begin
         r.mnemonic = w[22] ? MN_MOVT : MN_MOVW;
         r.reg_a = {1'b0, w[15:12]};
         r.operand_value = {48'd0, w[19:16], w[11:0]};
      end else if ((w & ALU_MASK) == ALU_MATCH) begin
         opc = w[24:21];
         is_cmp = (opc >= OPC_TST && opc <= OPC_CMN);
         r.mnemonic = MN_ALU_BASE + {2'b00, opc};
         r.reg_a = is_cmp ? 5'd0 : {1'b0, w[15:12]};
         r.reg_b = (opc == OPC_MOV || opc == OPC_MVN) ? 5'd0 : {1'b0, w[19:16]};
         r.reg_c = w[25] ? 5'd0 : {1'b0, w[3:0]};
         twice = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
         r.operand_value = w[25] ? {32'd0, twice[31:0]} : 64'd0;
         r.flag_update = ld && !is_cmp;
         r.operand_is_immediate = w[25];
      end else begin
         // vfp arithmetic, anything else stays unknown
         case (w & VAR_MASK)
            VADD_MATCH: r.mnemonic = MN_VADD;
            VSUB_MATCH: r.mnemonic = MN_VSUB;
            VMUL_MATCH: r.mnemonic = MN_VMUL;
            VDIV_MATCH: r.mnemonic = MN_VDIV;
            default: r.mnemonic = MN_UNKNOWN;
         endcase
         if (r.mnemonic != MN_UNKNOWN) begin
            dp = w[8];
            r.reg_a = vreg(w, 12, 22, dp);
            r.reg_b = vreg(w, 16, 7, dp);
            r.reg_c = vreg(w, 0, 5, dp);
            r.double_precision = dp;
         end
      end
      return r;
   endfunction

   // mask and match of each instruction form, for shaped random words
   function automatic logic [63:0] form_pattern(input int idx);
      logic [63:0] p;
      case (idx)
         0:  p = {BR_MASK, BR_MATCH};
         1:  p = {BX_MASK, BX_MATCH};
         2:  p = {BX_MASK, BLX_MATCH};
         3:  p = {SDT_MASK, SDT_MATCH};
         4:  p = {HW_MASK, HW_MATCH};
         5:  p = {BDT_MASK, BDT_MATCH};
         6:  p = {VM_MASK, VPAIR_A};
         7:  p = {VM_MASK, VPAIR_B};
         8:  p = {VMOVF_MASK, VMOVF_S};
         9:  p = {VMOVF_MASK, VMOVF_D};
         10: p = {VSGL_MASK, VSGL_TO};
         11: p = {VSGL_MASK, VSGL_FROM};
         12: p = {VM_MASK, CVT_S};
         13: p = {VM_MASK, CVT_U};
         14: p = {VM_MASK, CVT_NS};
         15: p = {COP_MASK | 32'h00000800, VLS_MATCH | 32'h00000800};
         16: p = {COP_MASK, SVC_MATCH};
         17: p = {MUL_MASK, MUL_MATCH};
         18: p = {MOV16_MASK, MOVW_MATCH};
         19: p = {MOV16_MASK, MOVT_MATCH};
         20: p = {ALU_MASK, ALU_MATCH};
         21: p = {VAR_MASK, VADD_MATCH};
         22: p = {VAR_MASK, VSUB_MATCH};
         23: p = {VAR_MASK, VMUL_MATCH};
         default: p = {VAR_MASK, VDIV_MATCH};
      endcase
      return p;
   endfunction

   // mostly well-formed words with random fields, some plain noise
   function automatic logic [31:0] rand_word();
      logic [31:0] raw;
      logic [63:0] p;
      raw = $urandom;
      if ($urandom_range(99) < 15) return raw;
      p = form_pattern($urandom_range(NUM_FORMS - 1));
      return (raw & ~p[63:32]) | p[31:0];
   endfunction

   // addresses, with some close to the top so branch targets wrap
   function automatic logic [63:0] rand_addr();
      logic [63:0] a;
      if ($urandom_range(7) == 0) a = ~{32'd0, $urandom_range(65535)};
      else a = {$urandom, $urandom};
      return a;
   endfunction

   function automatic rsp_type typed_rsp(input logic [MN_W-1:0] mn, input logic [3:0] cond,
                                         input logic [63:0] opv);
      rsp_type r;
      r = '0;
      r.mnemonic = mn;
      r.condition = cond;
      r.operand_value = opv;
      return r;
   endfunction

   task automatic add_row(input logic [31:0] w, input logic [63:0] a, input bit typed,
                          input rsp_type want);
      dir_row_type row;
      row.word = w;
      row.addr = a;
      row.typed = typed;
      row.want = want;
      dir_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_decode(input rsp_type want, input rsp_type got);
      check_field("mnemonic", want.mnemonic, got.mnemonic);
      check_field("condition", want.condition, got.condition);
      check_field("reg_a", want.reg_a, got.reg_a);
      check_field("reg_b", want.reg_b, got.reg_b);
      check_field("reg_c", want.reg_c, got.reg_c);
      check_field("operand_value", want.operand_value, got.operand_value);
      check_field("offset_down", want.offset_down, got.offset_down);
      check_field("writeback", want.writeback, got.writeback);
      check_field("pre_index", want.pre_index, got.pre_index);
      check_field("flag_update", want.flag_update, got.flag_update);
      check_field("double_precision", want.double_precision, got.double_precision);
      check_field("operand_is_immediate", want.operand_is_immediate,
                  got.operand_is_immediate);
   endtask

   // offer one word, hold it until the transfer
   task automatic send_item(input logic [31:0] w, input logic [63:0] a, input bit typed,
                            input rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data.instruction_word <= w;
      req_ch.data.instruction_address <= a;
      row_typed <= typed;
      row_typed_rsp <= want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // result side ready, with one long hold-off to back the block up
   initial begin
      rsp_ch.ready = 1'b0;
      holdoff_done = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_due && !holdoff_done) begin
            holdoff_done = 1'b1;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_ch.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // transfers on both sides, checking and timeout
   initial begin
      errors = 0;
      rsp_count = 0;
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            expected_decodes.push_back(row_typed ? row_typed_rsp :
               decode_a32(req_ch.data.instruction_word, req_ch.data.instruction_address));
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (expected_decodes.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual mnemonic %0d",
                        $time, rsp_ch.data.mnemonic);
            end else begin
               check_decode(expected_decodes.pop_front(), rsp_ch.data);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[arm_instruction_decoder_top] ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      row_typed = 1'b0;
      row_typed_rsp = '0;
      send_idle_pct = 35;
      rcv_idle_pct = 49;
      holdoff_due = 1'b0;
      random_sent = 0;

      // directed words: extremes, each form, fall-through cases
      add_row(32'h00000000, 64'd0, 1'b1, typed_rsp(MN_ALU_BASE, 4'h0, 64'd0));
      add_row(32'hffffffff, '1, 1'b1, typed_rsp(MN_SVC, 4'hf, 64'hffffff));
      add_row(32'hfe000000, '1, 1'b1, typed_rsp(MN_UNKNOWN, 4'hf, 64'd0));
      add_row(32'heaffffff, 64'd0, 1'b1, typed_rsp(MN_B, 4'he, 64'd4));
      add_row(32'h0b7fffff, 64'hffff_ffff_ffff_fff0, 1'b0, '0);
      add_row(32'he12fff1e, 64'd0, 1'b0, '0);
      add_row(32'he12fff3c, 64'd0, 1'b0, '0);
      add_row(32'he59f1004, 64'd0, 1'b0, '0);
      add_row(32'he4c12004, 64'd0, 1'b0, '0);
      add_row(32'he1d100f2, 64'd0, 1'b0, '0);
      add_row(32'he1d100d2, 64'd0, 1'b0, '0);
      add_row(32'he1c100b2, 64'd0, 1'b0, '0);
      // halfword store with the signed bit drops through to the alu decode
      add_row(32'he1c100d2, 64'd0, 1'b0, '0);
      add_row(32'he92d4ff0, 64'd0, 1'b0, '0);
      add_row(32'hec510b10, 64'd0, 1'b0, '0);
      add_row(32'heef01b41, 64'd0, 1'b0, '0);
      add_row(32'hee100a90, 64'd0, 1'b0, '0);
      add_row(32'hee011b90, 64'd0, 1'b0, '0);
      add_row(32'hee421b10, 64'd0, 1'b0, '0);
      add_row(32'hee1f2b30, 64'd0, 1'b0, '0);
      add_row(32'hed1d1a01, 64'd0, 1'b0, '0);
      add_row(32'he0010392, 64'd0, 1'b0, '0);
      add_row(32'he34a5bcd, 64'd0, 1'b0, '0);
      add_row(32'he3f014ff, 64'd0, 1'b0, '0);
      add_row(32'he1510002, 64'd0, 1'b0, '0);
      add_row(32'hee711b62, 64'd0, 1'b0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_item(dir_rows[i].word, dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].want);

      // random words over three idle mixes
      for (int n = 0; n < 3 * PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 3) holdoff_due <= 1'b1;
         if (n == PHASE_ITEMS) begin
            send_idle_pct = 49;
            rcv_idle_pct <= 35;
         end
         if (n == 2 * PHASE_ITEMS) begin
            send_idle_pct = 0;
            rcv_idle_pct <= 0;
         end
         send_item(rand_word(), rand_addr(), 1'b0, '0);
         random_sent++;
      end
      req_ch.valid <= 1'b0;

      // drain
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d decodes: %0d directed words, %0d shaped or noise words",
               rsp_count, dir_rows.size(), random_sent);
      $display("idle mixes 35/49, 49/35 and none, one result hold of %0d cycles",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("[arm_instruction_decoder_top] OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("[arm_instruction_decoder_top] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/aid_pkg.sv
rtl/aid_if.sv
rtl/aid_decode.sv
rtl/arm_instruction_decoder_top.sv
bench/tb_arm_instruction_decoder_top.sv
